/* hw/rtl/pbei_pkg.sv */
// pbei_pkg: shared constants for the packet bit-field extract/insert block
// action and status codes, fixed field widths of the item ports
// no dependencies
`default_nettype none

package pbei_pkg;

  // fixed item field widths
  localparam int ACT_W    = 2;
  localparam int BADDR_W  = 8;
  localparam int BYTE_W   = 8;
  localparam int BOFS_W   = 11;
  localparam int FWID_W   = 7;
  localparam int VAL_W    = 64;
  localparam int STAT_W   = 2;

  // field window: up to nine bytes touched by one field
  localparam int WIN_W    = 72;
  // bytes-per-field counter and byte index widths
  localparam int NB_W     = 4;
  localparam int BIDX_W   = 9;

  // action codes
  localparam logic [ACT_W-1:0] ACT_WRITE   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_READ    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_EXTRACT = 2'd2;
  localparam logic [ACT_W-1:0] ACT_INSERT  = 2'd3;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_WIDTH = 2'd1;
  localparam logic [STAT_W-1:0] ST_END   = 2'd2;

endpackage

`default_nettype wire

/* hw/rtl/packet_bitfield_extract_insert.sv */
// Packet buffer with MSB-first bit-field extract and insert.
// Input channel (in_*): one item per action: byte write, byte read, field extract or
//   field insert. Result channel (out_*): exactly one result item per input item.
// Bit 0 of the buffer is the MSB of byte 0; fields are 1 to MAX_FIELD_BITS bits.
// A field is handled one byte per cycle via the buffer's read and write ports:
//   extract reads from the first byte up, insert read-modify-writes last to first.
// Byte actions and refused fields (bad width, past end) go straight to the done
//   state; extract and insert first walk the nbytes buffer bytes that the field
//   touches (1 to 9).
// From the done state the result is loaded into an output register and shown on
//   out_valid; it is held there, and a new item is taken while it waits.
// When the receiver stalls, a finished item waits in its last stage until the
//   output register frees up, and no further item is accepted meanwhile.
// Reset (rst_n low, synchronous) clears the control state and out_valid; the
//   buffer contents are undefined until written.
// Depends on pbei_pkg.
`default_nettype none

module packet_bitfield_extract_insert #(
  parameter int BUFFER_BYTES   = 256,
  parameter int MAX_FIELD_BITS = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [pbei_pkg::ACT_W-1:0]       in_action,
  input  logic [pbei_pkg::BADDR_W-1:0]     in_byte_addr,
  input  logic [pbei_pkg::BYTE_W-1:0]      in_byte_data,
  input  logic [pbei_pkg::BOFS_W-1:0]      in_bit_offset,
  input  logic [pbei_pkg::FWID_W-1:0]      in_field_width,
  input  logic [pbei_pkg::VAL_W-1:0]       in_insert_value,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [pbei_pkg::VAL_W-1:0]       out_field_value,
  output logic [pbei_pkg::BYTE_W-1:0]      out_read_byte,
  output logic [pbei_pkg::FWID_W-1:0]      out_bits_done,
  output logic [pbei_pkg::STAT_W-1:0]      out_status
);
  import pbei_pkg::*;

  localparam int AW       = $clog2(BUFFER_BYTES);
  localparam int BUF_BITS = BUFFER_BYTES * 8;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_t;

  // control and item registers
  state_t              state_r;
  logic                out_valid_r;
  logic                rv_r;          // read data for pidx_r is in rdata_r
  logic                head_r;        // next processed byte is the field's first
  logic [ACT_W-1:0]    act_r;
  logic [STAT_W-1:0]   status_r;
  logic [FWID_W-1:0]   wid_r;
  logic [2:0]          tail_r;        // field end distance from LSB of last byte
  logic [2:0]          head_sh_r;     // field start bit within first byte
  logic [NB_W-1:0]     iss_left_r;
  logic [NB_W-1:0]     proc_left_r;
  logic [BIDX_W-1:0]   idx_r;         // next byte to read
  logic [BIDX_W-1:0]   pidx_r;        // byte being processed
  logic [WIN_W-1:0]    data_r;        // extract accumulator / insert value window
  logic [WIN_W-1:0]    msk_r;         // insert mask window

  // output registers
  logic [VAL_W-1:0]    out_fval_r;
  logic [BYTE_W-1:0]   out_rbyte_r;
  logic [FWID_W-1:0]   out_done_r;
  logic [STAT_W-1:0]   out_stat_r;

  // buffer
  logic [BYTE_W-1:0]   mem [BUFFER_BYTES];
  logic [BYTE_W-1:0]   rdata_r;
  logic                mem_we;
  logic [AW-1:0]       mem_wa;
  logic [BYTE_W-1:0]   mem_wd;
  logic                mem_re;
  logic [AW-1:0]       mem_ra;

  // accept-time decode
  logic                accept;
  logic                is_byte;
  logic                addr_bad;
  logic                wid_bad;
  logic                end_bad;
  logic [BOFS_W:0]     ofs_end;
  logic [BIDX_W-1:0]   first_b;
  logic [BIDX_W-1:0]   last_b;
  logic [NB_W-1:0]     nbytes;
  logic [2:0]          tail;
  logic [VAL_W-1:0]    wmask;
  logic [WIN_W-1:0]    val_win;
  logic [WIN_W-1:0]    msk_win;
  logic                issue;
  logic                out_free;
  logic [BYTE_W-1:0]   head_msk;
  logic [BYTE_W-1:0]   ext_byte;
  logic [BYTE_W-1:0]   ins_byte;

  assign in_stall        = (state_r != S_IDLE);
  assign accept          = in_valid && (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_field_value = out_fval_r;
  assign out_read_byte   = out_rbyte_r;
  assign out_bits_done   = out_done_r;
  assign out_status      = out_stat_r;
  assign out_free        = !out_valid_r || !out_stall;
  assign issue           = (state_r == S_RUN) && (iss_left_r != '0);

  // item decode: range checks and field window setup
  always_comb begin
    is_byte  = (in_action == ACT_WRITE) || (in_action == ACT_READ);
    addr_bad = 32'(in_byte_addr) >= 32'(BUFFER_BYTES);
    wid_bad  = (in_field_width == '0) || (32'(in_field_width) > 32'(MAX_FIELD_BITS));
    end_bad  = (32'(in_bit_offset) + 32'(in_field_width)) > 32'(BUF_BITS);
    ofs_end  = (BOFS_W+1)'(in_bit_offset) + (BOFS_W+1)'(in_field_width)
               - (BOFS_W+1)'(1);
    first_b  = BIDX_W'(in_bit_offset[BOFS_W-1:3]);
    last_b   = ofs_end[BOFS_W:3];
    nbytes   = NB_W'(last_b - first_b) + NB_W'(1);
    tail     = ~ofs_end[2:0];
    wmask    = ~({VAL_W{1'b1}} << in_field_width);
    val_win  = WIN_W'(in_insert_value & wmask) << tail;
    msk_win  = WIN_W'(wmask) << tail;
  end

  // per-byte datapath
  always_comb begin
    head_msk = head_r ? (8'hff >> head_sh_r) : 8'hff;
    ext_byte = rdata_r & head_msk;
    ins_byte = (rdata_r & ~msk_r[BYTE_W-1:0]) | (data_r[BYTE_W-1:0] & msk_r[BYTE_W-1:0]);
  end

  // buffer port selection
  always_comb begin
    mem_we = 1'b0;
    mem_wa = AW'(in_byte_addr);
    mem_wd = in_byte_data;
    mem_re = 1'b0;
    mem_ra = AW'(in_byte_addr);
    if (accept && (in_action == ACT_WRITE) && !addr_bad) begin
      mem_we = 1'b1;
    end else if ((state_r == S_RUN) && rv_r && (act_r == ACT_INSERT)) begin
      mem_we = 1'b1;
      mem_wa = AW'(pidx_r);
      mem_wd = ins_byte;
    end
    if (accept && (in_action == ACT_READ)) begin
      mem_re = 1'b1;
    end else if (issue) begin
      mem_re = 1'b1;
      mem_ra = AW'(idx_r);
    end
  end

  // packet buffer
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_ra];
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      rv_r        <= 1'b0;
    end else begin
      rv_r <= issue;
      // result taken while nothing new is being loaded
      if (out_valid_r && !out_stall && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            act_r     <= in_action;
            wid_r     <= in_field_width;
            tail_r    <= tail;
            head_sh_r <= in_bit_offset[2:0];
            head_r    <= 1'b1;
            if (is_byte) begin
              status_r <= addr_bad ? ST_END : ST_OK;
              state_r  <= S_DONE;
            end else if (wid_bad) begin
              status_r <= ST_WIDTH;
              state_r  <= S_DONE;
            end else if (end_bad) begin
              status_r <= ST_END;
              state_r  <= S_DONE;
            end else begin
              status_r    <= ST_OK;
              state_r     <= S_RUN;
              iss_left_r  <= nbytes;
              proc_left_r <= nbytes;
              msk_r       <= msk_win;
              if (in_action == ACT_EXTRACT) begin
                idx_r  <= first_b;
                pidx_r <= first_b;
                data_r <= '0;
              end else begin
                idx_r  <= last_b;
                pidx_r <= last_b;
                data_r <= val_win;
              end
            end
          end
        end
        S_RUN: begin
          // read issue, one byte per cycle
          if (issue) begin
            iss_left_r <= iss_left_r - NB_W'(1);
            idx_r      <= (act_r == ACT_EXTRACT) ? idx_r + BIDX_W'(1) : idx_r - BIDX_W'(1);
          end
          // byte processing in the cycle after its read is issued
          if (rv_r) begin
            head_r      <= 1'b0;
            proc_left_r <= proc_left_r - NB_W'(1);
            if (act_r == ACT_EXTRACT) begin
              data_r <= {data_r[WIN_W-BYTE_W-1:0], ext_byte};
              pidx_r <= pidx_r + BIDX_W'(1);
            end else begin
              data_r <= data_r >> BYTE_W;
              msk_r  <= msk_r >> BYTE_W;
              pidx_r <= pidx_r - BIDX_W'(1);
            end
            if (proc_left_r == NB_W'(1)) begin
              state_r <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_stat_r  <= status_r;
            out_fval_r  <= ((status_r == ST_OK) && (act_r == ACT_EXTRACT)) ?
                           VAL_W'(data_r >> tail_r) : '0;
            out_rbyte_r <= ((status_r == ST_OK) && (act_r == ACT_READ)) ? rdata_r : '0;
            out_done_r  <= ((status_r == ST_OK) &&
                            ((act_r == ACT_EXTRACT) || (act_r == ACT_INSERT))) ? wid_r : '0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// tb_top: self-checking testbench for packet_bitfield_extract_insert
// directed table then random items, each result checked against a typed value or a local packet model
// depends on pbei_pkg and packet_bitfield_extract_insert
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pbei_pkg::*;

  localparam int BUF_BYTES      = 256;
  localparam int MAX_BITS       = 64;
  localparam int PHASE_ITEMS    = 170;
  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 16;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [BADDR_W-1:0] byte_addr;
    logic [BYTE_W-1:0]  byte_data;
    logic [BOFS_W-1:0]  bit_offset;
    logic [FWID_W-1:0]  field_width;
    logic [VAL_W-1:0]   insert_value;
  } req_t;

  typedef struct packed {
    logic [VAL_W-1:0]  field_value;
    logic [BYTE_W-1:0] read_byte;
    logic [FWID_W-1:0] bits_done;
    logic [STAT_W-1:0] status;
  } resp_t;

  typedef struct packed {
    req_t  req;
    logic  typed;
    resp_t resp;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [ACT_W-1:0]   in_action;
  logic [BADDR_W-1:0] in_byte_addr;
  logic [BYTE_W-1:0]  in_byte_data;
  logic [BOFS_W-1:0]  in_bit_offset;
  logic [FWID_W-1:0]  in_field_width;
  logic [VAL_W-1:0]   in_insert_value;
  logic out_valid;
  logic out_stall;
  logic [VAL_W-1:0]   out_field_value;
  logic [BYTE_W-1:0]  out_read_byte;
  logic [FWID_W-1:0]  out_bits_done;
  logic [STAT_W-1:0]  out_status;

  // local copy of the packet buffer and which bytes have been written
  logic [7:0] packet_mirror [BUF_BYTES];
  bit         written_map   [BUF_BYTES];

  resp_t pending_results [$];
  dir_row_t dir_rows [$];

  int  errors;
  int  n_items;
  int  n_results;
  int  n_extracts;
  int  n_inserts;
  int  n_refused;
  int  send_pct;
  int  recv_pct;
  bit  hold_request;
  int  hold_left;

  packet_bitfield_extract_insert #(
    .BUFFER_BYTES  (BUF_BYTES),
    .MAX_FIELD_BITS(MAX_BITS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_byte_addr   (in_byte_addr),
    .in_byte_data   (in_byte_data),
    .in_bit_offset  (in_bit_offset),
    .in_field_width (in_field_width),
    .in_insert_value(in_insert_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_field_value(out_field_value),
    .out_read_byte  (out_read_byte),
    .out_bits_done  (out_bits_done),
    .out_status     (out_status)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // packet model: applies one item to the mirror and returns its result
  function automatic resp_t predict_action(req_t r);
    resp_t res;
    int    w;
    int    pos;
    int    i;
    res = '0;
    w   = int'(r.field_width);
    if (r.action == ACT_WRITE) begin
      packet_mirror[r.byte_addr] = r.byte_data;
      written_map[r.byte_addr]   = 1'b1;
    end else if (r.action == ACT_READ) begin
      res.read_byte = packet_mirror[r.byte_addr];
    end else if (w < 1 || w > MAX_BITS) begin
      res.status = ST_WIDTH;
    end else if (int'(r.bit_offset) + w > BUF_BYTES * 8) begin
      res.status = ST_END;
    end else begin
      // msb-first walk over the field
      for (i = 0; i < w; i++) begin
        pos = int'(r.bit_offset) + i;
        if (r.action == ACT_EXTRACT)
          res.field_value = {res.field_value[VAL_W-2:0], packet_mirror[pos/8][7-(pos%8)]};
        else
          packet_mirror[pos/8][7-(pos%8)] = r.insert_value[w-1-i];
      end
      res.bits_done = r.field_width;
    end
    return res;
  endfunction

  function automatic dir_row_t make_row(logic [ACT_W-1:0] act, int addr, int data,
                                        int offset, int width, logic [VAL_W-1:0] ival,
                                        bit typed, logic [VAL_W-1:0] fv, int rb, int bd,
                                        logic [STAT_W-1:0] st);
    dir_row_t row;
    row.req.action       = act;
    row.req.byte_addr    = addr[BADDR_W-1:0];
    row.req.byte_data    = data[BYTE_W-1:0];
    row.req.bit_offset   = offset[BOFS_W-1:0];
    row.req.field_width  = width[FWID_W-1:0];
    row.req.insert_value = ival;
    row.typed            = typed;
    row.resp.field_value = fv;
    row.resp.read_byte   = rb[BYTE_W-1:0];
    row.resp.bits_done   = bd[FWID_W-1:0];
    row.resp.status      = st;
    return row;
  endfunction

  // random item, mostly well-formed; anything touching an unwritten byte
  // becomes a write of that byte instead
  function automatic req_t pick_item();
    req_t r;
    int   roll;
    int   w;
    int   lo;
    int   hi;
    int   b;
    bit   in_range;
    r.action       = ACT_W'($urandom_range(3));
    r.byte_addr    = BADDR_W'($urandom);
    r.byte_data    = BYTE_W'($urandom);
    r.bit_offset   = BOFS_W'($urandom);
    r.field_width  = FWID_W'($urandom);
    r.insert_value = {$urandom, $urandom};
    in_range = 1'b0;
    lo = 0;
    hi = -1;
    if (r.action == ACT_READ) begin
      lo = int'(r.byte_addr);
      hi = lo;
    end else if (r.action == ACT_EXTRACT || r.action == ACT_INSERT) begin
      roll = $urandom_range(99);
      if (roll < 8) begin
        // bad width
        r.field_width = $urandom_range(1) ? FWID_W'(0) : FWID_W'($urandom_range(65, 127));
      end else if (roll < 15) begin
        // field runs past the buffer end
        w = $urandom_range(2, MAX_BITS);
        r.field_width = FWID_W'(w);
        r.bit_offset  = BOFS_W'($urandom_range(BUF_BYTES * 8 + 1 - w, BUF_BYTES * 8 - 1));
      end else begin
        w = ($urandom_range(3) == 0) ? MAX_BITS : $urandom_range(1, MAX_BITS);
        r.field_width = FWID_W'(w);
        r.bit_offset  = BOFS_W'($urandom_range(0, BUF_BYTES * 8 - w));
        lo = int'(r.bit_offset) / 8;
        hi = (int'(r.bit_offset) + w - 1) / 8;
      end
    end
    for (b = lo; b <= hi; b++) begin
      if (!written_map[b] && !in_range) begin
        in_range    = 1'b1;
        r.action    = ACT_WRITE;
        r.byte_addr = BADDR_W'(b);
      end
    end
    return r;
  endfunction

  // offer one item, hold it until taken, then record what it should return
  task automatic offer_item(req_t r, bit typed, resp_t typed_resp);
    resp_t pred;
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= r.action;
    in_byte_addr    <= r.byte_addr;
    in_byte_data    <= r.byte_data;
    in_bit_offset   <= r.bit_offset;
    in_field_width  <= r.field_width;
    in_insert_value <= r.insert_value;
    do @(posedge clk); while (in_stall);
    pred = predict_action(r);
    pending_results.push_back(typed ? typed_resp : pred);
    n_items++;
    if (pred.status != ST_OK) n_refused++;
    else if (r.action == ACT_EXTRACT) n_extracts++;
    else if (r.action == ACT_INSERT) n_inserts++;
  endtask

  task automatic check_field(string name, logic [VAL_W-1:0] exp_v, logic [VAL_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t ns: mismatch on %s: expected %h, got %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // result monitor
  initial begin
    resp_t exp_r;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        n_results++;
        if (pending_results.size() == 0) begin
          $display("%0t ns: result with nothing expected: value %h byte %h bits %0d status %0d",
                   $time, out_field_value, out_read_byte, out_bits_done, out_status);
          errors++;
        end else begin
          exp_r = pending_results.pop_front();
          check_field("field_value", exp_r.field_value, out_field_value);
          check_field("read_byte", VAL_W'(exp_r.read_byte), VAL_W'(out_read_byte));
          check_field("bits_done", VAL_W'(exp_r.bits_done), VAL_W'(out_bits_done));
          check_field("status", VAL_W'(exp_r.status), VAL_W'(out_status));
        end
      end
    end
  end

  // receiver stall, with a long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_pct);
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("timeout after %0d quiet cycles, %0d results outstanding",
             quiet, pending_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // main sequence
  initial begin
    int ph;
    int k;
    errors          = 0;
    n_items         = 0;
    n_results       = 0;
    n_extracts      = 0;
    n_inserts       = 0;
    n_refused       = 0;
    hold_request    = 1'b0;
    hold_left       = 0;
    send_pct        = 14;
    recv_pct        = 85;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_action       = ACT_WRITE;
    in_byte_addr    = '0;
    in_byte_data    = '0;
    in_bit_offset   = '0;
    in_field_width  = '0;
    in_insert_value = '0;
    for (k = 0; k < BUF_BYTES; k++) begin
      packet_mirror[k] = '0;
      written_map[k]   = 1'b0;
    end

    // directed table: first bytes and the last byte, extremes, refusals
    dir_rows.push_back(make_row(ACT_WRITE, 0, 8'hff, 0, 0, '0, 0, '0, 0, 0, ST_OK));
    dir_rows.push_back(make_row(ACT_WRITE, 1, 8'h00, 0, 0, '0, 0, '0, 0, 0, ST_OK));
    dir_rows.push_back(make_row(ACT_WRITE, 2, 8'ha5, 0, 0, '0, 0, '0, 0, 0, ST_OK));
    dir_rows.push_back(make_row(ACT_WRITE, 3, 8'h5a, 0, 0, '0, 0, '0, 0, 0, ST_OK));
    dir_rows.push_back(make_row(ACT_WRITE, 4, 8'h0f, 0, 0, '0, 0, '0, 0, 0, ST_OK));
    dir_rows.push_back(make_row(ACT_WRITE, 5, 8'hf0, 0, 0, '0, 0, '0, 0, 0, ST_OK));
    dir_rows.push_back(make_row(ACT_WRITE, 6, 8'h3c, 0, 0, '0, 0, '0, 0, 0, ST_OK));
    dir_rows.push_back(make_row(ACT_WRITE, 7, 8'hc3, 0, 0, '0, 0, '0, 0, 0, ST_OK));
    dir_rows.push_back(make_row(ACT_WRITE, 8, 8'h81, 0, 0, '0, 0, '0, 0, 0, ST_OK));
    dir_rows.push_back(make_row(ACT_WRITE, 255, 8'h00, 0, 0, '0, 0, '0, 0, 0, ST_OK));
    dir_rows.push_back(make_row(ACT_READ, 0, 0, 0, 0, '0, 1, '0, 8'hff, 0, ST_OK));
    dir_rows.push_back(make_row(ACT_READ, 255, 0, 0, 0, '0, 1, '0, 8'h00, 0, ST_OK));
    dir_rows.push_back(make_row(ACT_EXTRACT, 0, 0, 0, 1, '0, 1, 64'd1, 0, 1, ST_OK));
    dir_rows.push_back(make_row(ACT_EXTRACT, 0, 0, 2047, 1, '0, 1, 64'd0, 0, 1, ST_OK));
    dir_rows.push_back(make_row(ACT_EXTRACT, 0, 0, 3, 64, '0, 0, '0, 0, 0, ST_OK));
    dir_rows.push_back(make_row(ACT_EXTRACT, 0, 0, 0, 64, '0, 0, '0, 0, 0, ST_OK));
    dir_rows.push_back(make_row(ACT_EXTRACT, 0, 0, 0, 0, '0, 1, '0, 0, 0, ST_WIDTH));
    dir_rows.push_back(make_row(ACT_EXTRACT, 0, 0, 0, 65, '0, 1, '0, 0, 0, ST_WIDTH));
    dir_rows.push_back(make_row(ACT_INSERT, 0, 0, 0, 127, '1, 1, '0, 0, 0, ST_WIDTH));
    dir_rows.push_back(make_row(ACT_EXTRACT, 0, 0, 2047, 2, '0, 1, '0, 0, 0, ST_END));
    dir_rows.push_back(make_row(ACT_INSERT, 0, 0, 1985, 64, '1, 1, '0, 0, 0, ST_END));
    dir_rows.push_back(make_row(ACT_INSERT, 0, 0, 5, 64, '1, 0, '0, 0, 0, ST_OK));
    dir_rows.push_back(make_row(ACT_INSERT, 0, 0, 2047, 1, 64'd1, 1, '0, 0, 1, ST_OK));
    dir_rows.push_back(make_row(ACT_EXTRACT, 0, 0, 0, 64, '0, 0, '0, 0, 0, ST_OK));
    dir_rows.push_back(make_row(ACT_READ, 8, 0, 0, 0, '0, 0, '0, 0, 0, ST_OK));

    // reset
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[k]) offer_item(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].resp);

    // random phases: slow receiver, slow sender, then no idling with a long hold-off
    for (ph = 0; ph < 3; ph++) begin
      send_pct = (ph == 0) ? 14 : (ph == 1) ? 85 : 0;
      recv_pct = (ph == 0) ? 85 : (ph == 1) ? 14 : 0;
      if (ph == 2) hold_request = 1'b1;
      for (k = 0; k < PHASE_ITEMS; k++) offer_item(pick_item(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    // drain
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d items: %0d extracts, %0d inserts, %0d refused fields",
             n_items, n_extracts, n_inserts, n_refused);
    $display("%0d results compared, %0d mismatches", n_results, errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
